// ===== rtl/fdsp_pkg.sv =====
// Shared widths, constants and the per-item pipeline record of the Fresnel sampler.
package fdsp_pkg;

  // Square root: one result bit per stage.
  localparam int SQ_ST = 16;

  // Ratio divider: floor(num * 2^16 / den) with num <= den, one quotient bit per stage.
  localparam int FD_W = 35;
  localparam int FD_Q = 17;

  // Weight divider: 33-bit dividend over 16-bit divisor, one quotient bit per stage.
  localparam int WN_W = 33;
  localparam int WD_W = 16;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [16:0] ONE_Q16 = 17'h1_0000;

  // Everything an item carries down the pipeline; unused fields trim away.
  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] c;
    logic [15:0]        eta;
    logic [2:0][15:0]   refl;
    logic [2:0][15:0]   trans;
    logic [15:0]        pick;
    logic [1:0]         mask;
    logic               bad;
    logic [16:0]        sum_r;
    logic [16:0]        sum_t;
    logic [15:0]        cos_t;
    logic [16:0]        fr;
    logic               no_pow;
    logic               xmit;
    logic [16:0]        pdf;
    logic [2:0]         wneg;
    logic [15:0]        ox;
    logic [15:0]        oy;
    logic [15:0]        oz;
  } item_t;

endpackage

// ===== rtl/fdsp_sqrt.sv =====
// Pipelined integer square root of a 31-bit radicand, one root bit per stage.
module fdsp_sqrt import fdsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  item_t       item_i,
  input  logic [30:0] rad_i,
  output logic        vld_o,
  output item_t       item_o,
  output logic [15:0] root_o
);

  logic        v_q   [SQ_ST];
  item_t       it_q  [SQ_ST];
  logic [30:0] rem_q [SQ_ST];
  logic [31:0] r_q   [SQ_ST];

  for (genvar g = 0; g < SQ_ST; g++) begin : g_st
    localparam logic [31:0] Bit = 32'd1 << (30 - 2 * g);
    logic        v_in;
    item_t       it_in;
    logic [30:0] rem_in;
    logic [31:0] r_in;
    logic [32:0] trial;
    logic [30:0] rem_d;
    logic [31:0] r_d;

    if (g == 0) begin : g_head
      assign v_in   = vld_i;
      assign it_in  = item_i;
      assign rem_in = rad_i;
      assign r_in   = '0;
    end else begin : g_body
      assign v_in   = v_q[g-1];
      assign it_in  = it_q[g-1];
      assign rem_in = rem_q[g-1];
      assign r_in   = r_q[g-1];
    end

    // Try the next root bit; keep it when the remainder covers it
    always_comb begin
      trial = {1'b0, r_in} + {1'b0, Bit};
      if ({2'b00, rem_in} >= trial) begin
        rem_d = rem_in - trial[30:0];
        r_d   = (r_in >> 1) + Bit;
      end else begin
        rem_d = rem_in;
        r_d   = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        it_q[g]  <= it_in;
        rem_q[g] <= rem_d;
        r_q[g]   <= r_d;
      end
    end
  end

  assign vld_o  = v_q[SQ_ST-1];
  assign item_o = it_q[SQ_ST-1];
  assign root_o = r_q[SQ_ST-1][15:0];

endmodule

// ===== rtl/fdsp_fdiv.sv =====
// Two-lane pipelined fraction divider: floor(num * 2^16 / den) for num <= den.
module fdsp_fdiv import fdsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  item_t                item_i,
  input  logic [1:0][FD_W-1:0] num_i,
  input  logic [1:0][FD_W-1:0] den_i,
  output logic                 vld_o,
  output item_t                item_o,
  output logic [1:0][FD_Q-1:0] q_o
);

  logic                 v_q  [FD_Q];
  item_t                it_q [FD_Q];
  logic [1:0][FD_W-1:0] r_q  [FD_Q];
  logic [1:0][FD_W-1:0] d_q  [FD_Q];
  logic [1:0][FD_Q-1:0] qq_q [FD_Q];

  for (genvar g = 0; g < FD_Q; g++) begin : g_st
    logic                 v_in;
    item_t                it_in;
    logic [1:0][FD_W-1:0] r_in;
    logic [1:0][FD_W-1:0] d_in;
    logic [1:0][FD_Q-1:0] q_in;
    logic [1:0][FD_W-1:0] r_d;
    logic [1:0][FD_Q-1:0] q_d;
    logic [FD_W:0]        cand [2];
    logic [1:0]           ge;

    if (g == 0) begin : g_head
      assign v_in  = vld_i;
      assign it_in = item_i;
      assign r_in  = num_i;
      assign d_in  = den_i;
      assign q_in  = '0;
    end else begin : g_body
      assign v_in  = v_q[g-1];
      assign it_in = it_q[g-1];
      assign r_in  = r_q[g-1];
      assign d_in  = d_q[g-1];
      assign q_in  = qq_q[g-1];
    end

    // Restoring step: the first stage takes the integer bit, later ones shift first
    always_comb begin
      logic [FD_W:0] diff;
      diff = '0;
      for (int l = 0; l < 2; l++) begin
        cand[l] = (g == 0) ? {1'b0, r_in[l]} : {r_in[l], 1'b0};
        ge[l]   = cand[l] >= {1'b0, d_in[l]};
        diff    = cand[l] - {1'b0, d_in[l]};
        r_d[l]  = ge[l] ? diff[FD_W-1:0] : cand[l][FD_W-1:0];
        q_d[l]  = {q_in[l][FD_Q-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        it_q[g] <= it_in;
        r_q[g]  <= r_d;
        d_q[g]  <= d_in;
        qq_q[g] <= q_d;
      end
    end
  end

  assign vld_o  = v_q[FD_Q-1];
  assign item_o = it_q[FD_Q-1];
  assign q_o    = qq_q[FD_Q-1];

endmodule

// ===== rtl/fdsp_wdiv.sv =====
// Three-lane pipelined integer divider for the weights, shared divisor, one bit per stage.
module fdsp_wdiv import fdsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  item_t                item_i,
  input  logic [2:0][WN_W-1:0] num_i,
  input  logic [WD_W-1:0]      den_i,
  output logic                 vld_o,
  output item_t                item_o,
  output logic [2:0][WN_W-1:0] q_o
);

  logic                 v_q  [WN_W];
  item_t                it_q [WN_W];
  logic [2:0][WD_W-1:0] r_q  [WN_W];
  logic [2:0][WN_W-1:0] nq_q [WN_W];
  logic [WD_W-1:0]      d_q  [WN_W];

  for (genvar g = 0; g < WN_W; g++) begin : g_st
    logic                 v_in;
    item_t                it_in;
    logic [2:0][WD_W-1:0] r_in;
    logic [2:0][WN_W-1:0] nq_in;
    logic [WD_W-1:0]      d_in;
    logic [2:0][WD_W-1:0] r_d;
    logic [2:0][WN_W-1:0] nq_d;
    logic [WD_W:0]        cand [3];
    logic [2:0]           ge;

    if (g == 0) begin : g_head
      assign v_in  = vld_i;
      assign it_in = item_i;
      assign r_in  = '0;
      assign nq_in = num_i;
      assign d_in  = den_i;
    end else begin : g_body
      assign v_in  = v_q[g-1];
      assign it_in = it_q[g-1];
      assign r_in  = r_q[g-1];
      assign nq_in = nq_q[g-1];
      assign d_in  = d_q[g-1];
    end

    // Shift the next dividend bit into the remainder, shift the quotient bit in below
    always_comb begin
      logic [WD_W:0] diff;
      diff = '0;
      for (int l = 0; l < 3; l++) begin
        cand[l] = {r_in[l], nq_in[l][WN_W-1]};
        ge[l]   = cand[l] >= {1'b0, d_in};
        diff    = cand[l] - {1'b0, d_in};
        r_d[l]  = ge[l] ? diff[WD_W-1:0] : cand[l][WD_W-1:0];
        nq_d[l] = {nq_in[l][WN_W-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        it_q[g] <= it_in;
        r_q[g]  <= r_d;
        nq_q[g] <= nq_d;
        d_q[g]  <= d_in;
      end
    end
  end

  assign vld_o  = v_q[WN_W-1];
  assign item_o = it_q[WN_W-1];
  assign q_o    = nq_q[WN_W-1];

endmodule

// ===== rtl/fresnel_dielectric_sampler.sv =====
// Fresnel dielectric specular sampler: takes ray hits and returns one sample per hit.
// The block accepts one hit every cycle unless back pressure stalls it, and returns results
// in order. Its depth comes from the bit-serial units in the pipeline: a 16-stage square
// root for the refracted cosine, two 17-stage fraction dividers (Fresnel amplitude ratios,
// then the reflect probability) and a 33-stage divider for the three weights. The whole
// pipeline advances together whenever the output register is empty or being drained, so
// back pressure on the result side stalls intake and nothing is dropped or repeated. The
// output register is the last stage. There is no configuration and no state between hits.
module fresnel_dielectric_sampler import fdsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] dir_in_x_i,
  input  logic signed [15:0] dir_in_y_i,
  input  logic signed [15:0] dir_in_z_i,
  input  logic [15:0]        eta_ratio_i,
  input  logic signed [15:0] refl_red_i,
  input  logic signed [15:0] refl_green_i,
  input  logic signed [15:0] refl_blue_i,
  input  logic signed [15:0] trans_red_i,
  input  logic signed [15:0] trans_green_i,
  input  logic signed [15:0] trans_blue_i,
  input  logic [15:0]        pick_sample_i,
  input  logic [1:0]         allowed_mask_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               sample_valid_o,
  output logic               is_transmit_o,
  output logic signed [15:0] dir_out_x_o,
  output logic signed [15:0] dir_out_y_o,
  output logic signed [15:0] dir_out_z_o,
  output logic signed [31:0] weight_red_o,
  output logic signed [31:0] weight_green_o,
  output logic signed [31:0] weight_blue_o,
  output logic [16:0]        branch_pdf_o
);

  function automatic logic [15:0] mag16(input logic [15:0] v);
    mag16 = v[15] ? (~v + 16'd1) : v;
  endfunction

  // Direction component from a rounded eta * |d| magnitude, sign opposite to d
  function automatic logic [15:0] refr16(input logic [15:0] d, input logic [31:0] m);
    logic [32:0] s;
    logic [20:0] r;
    s = {1'b0, m} + 33'd2048;
    r = s[32:12];
    if (!d[15] && (d != '0)) begin
      refr16 = (r > 21'd32768) ? 16'h8000 : (~r[15:0] + 16'd1);
    end else begin
      refr16 = (r > 21'd32767) ? 16'h7FFF : r[15:0];
    end
  endfunction

  function automatic logic [15:0] mirr16(input logic [15:0] d);
    mirr16 = (d == 16'h8000) ? 16'h7FFF : (~d + 16'd1);
  endfunction

  function automatic logic [31:0] wsat(input logic neg, input logic [WN_W-1:0] q);
    if (neg) begin
      wsat = (q > 33'h0_8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end else begin
      wsat = (q[32] || q[31]) ? 32'h7FFF_FFFF : q[31:0];
    end
  endfunction

  logic adv;
  logic out_v_q;

  // Whole pipeline moves when the output register is free or being taken
  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- stage a: capture, squares, absolute sums ----------------
  logic        va_q;
  item_t       it_a_d, it_a_q;
  logic [31:0] eta2_a_q;
  logic [29:0] csq_a_q;
  logic [15:0] eta_fix;

  assign eta_fix = (eta_ratio_i == '0) ? 16'd1 : eta_ratio_i;

  always_comb begin
    it_a_d       = '0;
    it_a_d.dx    = dir_in_x_i;
    it_a_d.dy    = dir_in_y_i;
    it_a_d.c     = dir_in_z_i;
    it_a_d.eta   = eta_fix;
    it_a_d.refl  = {refl_blue_i, refl_green_i, refl_red_i};
    it_a_d.trans = {trans_blue_i, trans_green_i, trans_red_i};
    it_a_d.pick  = pick_sample_i;
    it_a_d.mask  = allowed_mask_i;
    it_a_d.bad   = dir_in_z_i[15] || (dir_in_z_i == '0);
    it_a_d.sum_r = {1'b0, mag16(refl_red_i)} + {1'b0, mag16(refl_green_i)}
                 + {1'b0, mag16(refl_blue_i)};
    it_a_d.sum_t = {1'b0, mag16(trans_red_i)} + {1'b0, mag16(trans_green_i)}
                 + {1'b0, mag16(trans_blue_i)};
  end

  // ---------------- stage b: eta^2 * (1 - cos^2) ----------------
  logic        vb_q;
  item_t       it_b_q;
  logic [62:0] prod_b_q;
  logic [30:0] om_a;

  assign om_a = ONE_Q30 - {1'b0, csq_a_q};

  // ---------------- stage c: sin^2 of the refracted ray, radicand ----------------
  logic        vc_q;
  item_t       it_c_q;
  logic [30:0] rad_c_q;
  logic        tir_b;

  assign tir_b = |prod_b_q[62:54];

  // ---------------- square root ----------------
  logic        vs;
  item_t       it_s;
  logic [15:0] root_s;

  fdsp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vc_q),
    .item_i (it_c_q),
    .rad_i  (rad_c_q),
    .vld_o  (vs),
    .item_o (it_s),
    .root_o (root_s)
  );

  // ---------------- stage d: eta * cosI, eta * cosT ----------------
  logic        vd_q;
  item_t       it_d_d, it_d_q;
  logic [30:0] ec_d_q;
  logic [31:0] ect_d_q;

  // Attach the refracted cosine to the item
  always_comb begin
    it_d_d       = it_s;
    it_d_d.cos_t = root_s;
  end

  // ---------------- stage e: amplitude numerators and denominators ----------------
  logic                 ve_q;
  item_t                it_e_q;
  logic [1:0][FD_W-1:0] num_e_d, den_e_d, num_e_q, den_e_q;

  always_comb begin
    logic [FD_W-1:0] a1, b1, a2, b2;
    a1 = {4'b0, ec_d_q};
    b1 = {7'b0, it_d_q.cos_t, 12'b0};
    a2 = {8'b0, it_d_q.c[14:0], 12'b0};
    b2 = {3'b0, ect_d_q};
    num_e_d[0] = (a1 >= b1) ? (a1 - b1) : (b1 - a1);
    den_e_d[0] = a1 + b1;
    num_e_d[1] = (a2 >= b2) ? (a2 - b2) : (b2 - a2);
    den_e_d[1] = a2 + b2;
  end

  // ---------------- amplitude ratios ----------------
  logic                 vf;
  item_t                it_f;
  logic [1:0][FD_Q-1:0] rat_f;

  fdsp_fdiv u_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (ve_q),
    .item_i (it_e_q),
    .num_i  (num_e_q),
    .den_i  (den_e_q),
    .vld_o  (vf),
    .item_o (it_f),
    .q_o    (rat_f)
  );

  // ---------------- stage g: squared ratios ----------------
  logic             vg_q;
  item_t            it_g_q;
  logic [1:0][33:0] sq_g_q;

  // ---------------- stage h: Fresnel reflectance ----------------
  logic        vh_q;
  item_t       it_h_d, it_h_q;

  always_comb begin
    logic [34:0] s;
    s      = {1'b0, sq_g_q[0]} + {1'b0, sq_g_q[1]} + 35'h1_0000;
    it_h_d = it_g_q;
    it_h_d.fr = (it_g_q.cos_t == '0) ? ONE_Q16 : s[33:17];
  end

  // ---------------- stage i: branch powers ----------------
  logic        vi_q;
  item_t       it_i_q;
  logic [33:0] powr_i_q, powt_i_q;

  // ---------------- stage j: total power ----------------
  logic                 vj_q;
  item_t                it_j_d, it_j_q;
  logic [1:0][FD_W-1:0] pnum_j_d, pden_j_d, pnum_j_q, pden_j_q;

  always_comb begin
    logic [FD_W-1:0] tot;
    tot           = {1'b0, powr_i_q} + {1'b0, powt_i_q};
    it_j_d        = it_i_q;
    it_j_d.no_pow = (tot == '0);
    pnum_j_d      = '0;
    pden_j_d      = '0;
    pnum_j_d[0]   = {1'b0, powr_i_q};
    pden_j_d[0]   = tot;
  end

  // ---------------- reflect probability ----------------
  logic                 vk;
  item_t                it_k;
  logic [1:0][FD_Q-1:0] prob_k;

  fdsp_fdiv u_prob (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vj_q),
    .item_i (it_j_q),
    .num_i  (pnum_j_q),
    .den_i  (pden_j_q),
    .vld_o  (vk),
    .item_o (it_k),
    .q_o    (prob_k)
  );

  // ---------------- stage l: branch pick, weight numerators ----------------
  logic                 vl_q;
  item_t                it_l_d, it_l_q;
  logic [2:0][WN_W-1:0] wn_l_d, wn_l_q;
  logic [WD_W-1:0]      wd_l_d, wd_l_q;
  logic [31:0]          mx_l_q, my_l_q;

  always_comb begin
    logic [16:0] fsel;
    logic [15:0] ms;
    logic [32:0] p;
    it_l_d      = it_k;
    it_l_d.xmit = !({1'b0, it_k.pick} < prob_k[0]);
    it_l_d.pdf  = it_l_d.xmit ? (ONE_Q16 - prob_k[0]) : prob_k[0];
    fsel        = it_l_d.xmit ? (ONE_Q16 - it_k.fr) : it_k.fr;
    ms          = '0;
    p           = '0;
    for (int k = 0; k < 3; k++) begin
      ms             = it_l_d.xmit ? it_k.trans[k] : it_k.refl[k];
      p              = {17'b0, mag16(ms)} * {16'b0, fsel};
      wn_l_d[k]      = {p[31:0], 1'b0};
      it_l_d.wneg[k] = ms[15];
    end
    if (it_l_d.xmit) begin
      wd_l_d    = (it_k.cos_t == '0) ? 16'd1 : it_k.cos_t;
      it_l_d.oz = ~it_k.cos_t + 16'd1;
    end else begin
      wd_l_d    = it_k.c;
      it_l_d.oz = it_k.c;
    end
  end

  // ---------------- stage m: outgoing x and y ----------------
  logic                 vm_q;
  item_t                it_m_d, it_m_q;
  logic [2:0][WN_W-1:0] wn_m_q;
  logic [WD_W-1:0]      wd_m_q;

  always_comb begin
    it_m_d = it_l_q;
    if (it_l_q.xmit) begin
      it_m_d.ox = refr16(it_l_q.dx, mx_l_q);
      it_m_d.oy = refr16(it_l_q.dy, my_l_q);
    end else begin
      it_m_d.ox = mirr16(it_l_q.dx);
      it_m_d.oy = mirr16(it_l_q.dy);
    end
  end

  // ---------------- weight division ----------------
  logic                 vw;
  item_t                it_w;
  logic [2:0][WN_W-1:0] wq_w;

  fdsp_wdiv u_wdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vm_q),
    .item_i (it_m_q),
    .num_i  (wn_m_q),
    .den_i  (wd_m_q),
    .vld_o  (vw),
    .item_o (it_w),
    .q_o    (wq_w)
  );

  // ---------------- output register ----------------
  logic        smp_q, xmit_q;
  logic [15:0] ox_q, oy_q, oz_q;
  logic [31:0] wr_q, wg_q, wb_q;
  logic [16:0] pdf_q;
  logic        ok_w;

  assign ok_w = !it_w.bad && !it_w.no_pow;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vc_q    <= 1'b0;
      vd_q    <= 1'b0;
      ve_q    <= 1'b0;
      vg_q    <= 1'b0;
      vh_q    <= 1'b0;
      vi_q    <= 1'b0;
      vj_q    <= 1'b0;
      vl_q    <= 1'b0;
      vm_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      va_q    <= in_valid_i;
      vb_q    <= va_q;
      vc_q    <= vb_q;
      vd_q    <= vs;
      ve_q    <= vd_q;
      vg_q    <= vf;
      vh_q    <= vg_q;
      vi_q    <= vh_q;
      vj_q    <= vi_q;
      vl_q    <= vk;
      vm_q    <= vl_q;
      out_v_q <= vw;
    end
  end

  // Advance payload; hold everything on a stall
  always_ff @(posedge clk_i) begin
    if (adv) begin
      it_a_q   <= it_a_d;
      eta2_a_q <= {16'b0, eta_fix} * {16'b0, eta_fix};
      csq_a_q  <= {15'b0, dir_in_z_i[14:0]} * {15'b0, dir_in_z_i[14:0]};

      it_b_q   <= it_a_q;
      prod_b_q <= {31'b0, eta2_a_q} * {32'b0, om_a};

      it_c_q   <= it_b_q;
      rad_c_q  <= tir_b ? 31'd0 : (ONE_Q30 - {1'b0, prod_b_q[53:24]});

      it_d_q       <= it_d_d;
      ec_d_q       <= {15'b0, it_s.eta} * {16'b0, it_s.c[14:0]};
      ect_d_q      <= {16'b0, it_s.eta} * {16'b0, root_s};

      it_e_q  <= it_d_q;
      num_e_q <= num_e_d;
      den_e_q <= den_e_d;

      it_g_q    <= it_f;
      sq_g_q[0] <= {17'b0, rat_f[0]} * {17'b0, rat_f[0]};
      sq_g_q[1] <= {17'b0, rat_f[1]} * {17'b0, rat_f[1]};

      it_h_q <= it_h_d;

      it_i_q   <= it_h_q;
      powr_i_q <= it_h_q.mask[0] ? ({17'b0, it_h_q.sum_r} * {17'b0, it_h_q.fr}) : '0;
      powt_i_q <= it_h_q.mask[1] ? ({17'b0, it_h_q.sum_t} * {17'b0, ONE_Q16 - it_h_q.fr})
                                 : '0;

      it_j_q   <= it_j_d;
      pnum_j_q <= pnum_j_d;
      pden_j_q <= pden_j_d;

      it_l_q <= it_l_d;
      wn_l_q <= wn_l_d;
      wd_l_q <= wd_l_d;
      mx_l_q <= {16'b0, it_k.eta} * {16'b0, mag16(it_k.dx)};
      my_l_q <= {16'b0, it_k.eta} * {16'b0, mag16(it_k.dy)};

      it_m_q <= it_m_d;
      wn_m_q <= wn_l_q;
      wd_m_q <= wd_l_q;

      // Drop every field of an invalid sample to zero
      smp_q  <= ok_w;
      xmit_q <= ok_w && it_w.xmit;
      ox_q   <= ok_w ? it_w.ox : '0;
      oy_q   <= ok_w ? it_w.oy : '0;
      oz_q   <= ok_w ? it_w.oz : '0;
      wr_q   <= ok_w ? wsat(it_w.wneg[0], wq_w[0]) : '0;
      wg_q   <= ok_w ? wsat(it_w.wneg[1], wq_w[1]) : '0;
      wb_q   <= ok_w ? wsat(it_w.wneg[2], wq_w[2]) : '0;
      pdf_q  <= ok_w ? it_w.pdf : '0;
    end
  end

  assign out_valid_o    = out_v_q;
  assign sample_valid_o = smp_q;
  assign is_transmit_o  = xmit_q;
  assign dir_out_x_o    = ox_q;
  assign dir_out_y_o    = oy_q;
  assign dir_out_z_o    = oz_q;
  assign weight_red_o   = wr_q;
  assign weight_green_o = wg_q;
  assign weight_blue_o  = wb_q;
  assign branch_pdf_o   = pdf_q;

  // Probability of a sampled branch never exceeds one
  a_pdf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_valid_o |-> branch_pdf_o <= ONE_Q16)
    else $error("branch probability above one");

  // An invalid sample carries only zeros
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sample_valid_o |-> !is_transmit_o && dir_out_z_o == '0 &&
      weight_red_o == '0 && branch_pdf_o == '0)
    else $error("invalid sample with nonzero fields");

  // A mirrored ray stays on the incoming side
  a_refl_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_valid_o && !is_transmit_o |->
      !dir_out_z_o[15] && dir_out_z_o != '0)
    else $error("reflected direction not above the surface");

  // A refracted ray always crosses to the other side
  a_refr_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_valid_o && is_transmit_o |-> dir_out_z_o[15])
    else $error("transmitted direction not below the surface");

endmodule
